>>> hw/rtl/bu_pkg.sv
// bu_pkg: shared types and codes for the bit unstuffer
// no dependencies; used by every module of the block
`default_nettype none

package bu_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_ELEMENT = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_COUNT_SIZE = 2'd1;
    localparam logic [1:0] ERR_WIDTH      = 2'd2;

    // queue job codes
    localparam logic [1:0] OP_HEADER = 2'd0;
    localparam logic [1:0] OP_ERROR  = 2'd1;
    localparam logic [1:0] OP_WORD   = 2'd2;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    localparam int BYTES_W = 34;

    // one job from the front to the back; data is the count or a data word
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] data;
        logic [4:0]  width;
        logic [1:0]  err;
        logic        last;
    } job_t;

endpackage

`default_nettype wire

>>> hw/rtl/bu_fifo.sv
// bu_fifo: short job queue between the front and the back
// depends on bu_pkg
`default_nettype none

module bu_fifo (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              wr_en,
    input  bu_pkg::job_t     wr_data,
    output logic             full,
    input  wire              rd_en,
    output bu_pkg::job_t     rd_data,
    output logic             empty
);

    bu_pkg::job_t                 mem_reg [bu_pkg::FIFO_DEPTH];
    logic [bu_pkg::FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bu_pkg::FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bu_pkg::FIFO_AW:0]     count_reg, count_next;

    assign full    = (count_reg == (bu_pkg::FIFO_AW+1)'(bu_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + (bu_pkg::FIFO_AW)'(wr_en);
        rd_ptr_next = rd_ptr_reg + (bu_pkg::FIFO_AW)'(rd_en);
        count_next  = count_reg + (bu_pkg::FIFO_AW+1)'(wr_en)
                      - (bu_pkg::FIFO_AW+1)'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && full))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && empty))
        else $error("job queue read while empty");

endmodule

`default_nettype wire

>>> hw/rtl/bu_front.sv
// bu_front: takes bytes, parses header and count, assembles data words
// depends on bu_pkg; pushes jobs into bu_fifo
`default_nettype none

module bu_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [7:0]          s_data_byte,
    input  wire                 q_full,
    output logic                q_push,
    output bu_pkg::job_t        q_job
);

    localparam logic [1:0] PH_HEADER    = 2'd0;
    localparam logic [1:0] PH_COUNT     = 2'd1;
    localparam logic [1:0] PH_DATA      = 2'd2;
    localparam logic [1:0] PH_COUNT_BAD = 2'd3;

    logic [1:0]                  phase_reg, phase_next;
    logic [2:0]                  cnt_left_reg, cnt_left_next;
    logic [31:0]                 accum_reg, accum_next;
    logic [4:0]                  width_reg, width_next;
    logic [1:0]                  biw_reg, biw_next;
    logic [bu_pkg::BYTES_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [31:0]                 word_reg, word_next;

    logic        accept;
    logic [31:0] lane;
    logic [36:0] bits;
    logic [31:0] full_word;
    logic [31:0] aligned;
    logic [1:0]  biw_inc;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign lane    = {24'd0, s_data_byte} << {biw_reg, 3'b000};
    assign bits    = 37'(accum_reg | lane) * 37'(width_reg) + 37'd7;
    assign full_word = word_reg | lane;
    assign biw_inc = biw_reg + 2'd1;

    // last partial word goes to the top bytes
    always_comb begin
        case (biw_inc)
            2'd1:    aligned = full_word << 24;
            2'd2:    aligned = full_word << 16;
            2'd3:    aligned = full_word << 8;
            default: aligned = full_word;
        endcase
    end

    always_comb begin
        phase_next      = phase_reg;
        cnt_left_next   = cnt_left_reg;
        accum_next      = accum_reg;
        width_next      = width_reg;
        biw_next        = biw_reg;
        bytes_left_next = bytes_left_reg;
        word_next       = word_reg;
        q_push          = 1'b0;
        q_job.op        = bu_pkg::OP_HEADER;
        q_job.data      = accum_reg | lane;
        q_job.width     = width_reg;
        q_job.err       = bu_pkg::ERR_NONE;
        q_job.last      = 1'b1;

        if (accept) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (s_data_byte[7:6] == 2'd3) begin
                        q_push    = 1'b1;
                        q_job.op  = bu_pkg::OP_ERROR;
                        q_job.err = bu_pkg::ERR_COUNT_SIZE;
                    end else begin
                        case (s_data_byte[7:6])
                            2'd0:    cnt_left_next = 3'd4;
                            2'd1:    cnt_left_next = 3'd2;
                            default: cnt_left_next = 3'd1;
                        endcase
                        accum_next = '0;
                        biw_next   = '0;
                        if (s_data_byte[5]) begin
                            width_next = '0;
                            phase_next = PH_COUNT_BAD;
                        end else begin
                            width_next = s_data_byte[4:0];
                            phase_next = PH_COUNT;
                        end
                    end
                end
                PH_COUNT, PH_COUNT_BAD: begin
                    accum_next    = accum_reg | lane;
                    biw_next      = biw_reg + 2'd1;
                    cnt_left_next = cnt_left_reg - 3'd1;
                    if (cnt_left_next == 3'd0) begin
                        biw_next   = '0;
                        phase_next = PH_HEADER;
                        q_push     = 1'b1;
                        if (phase_reg == PH_COUNT_BAD) begin
                            q_job.op  = bu_pkg::OP_ERROR;
                            q_job.err = bu_pkg::ERR_WIDTH;
                        end else if (accum_next == '0 || width_reg == '0) begin
                            q_job.op = bu_pkg::OP_HEADER;
                        end else begin
                            q_job.op        = bu_pkg::OP_HEADER;
                            q_job.last      = 1'b0;
                            bytes_left_next = bits[36:3];
                            word_next       = '0;
                            phase_next      = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    word_next       = full_word;
                    biw_next        = biw_inc;
                    bytes_left_next = bytes_left_reg - (bu_pkg::BYTES_W)'(1);
                    if (biw_next == 2'd0 || bytes_left_next == '0) begin
                        q_push     = 1'b1;
                        q_job.op   = bu_pkg::OP_WORD;
                        q_job.data = aligned;
                        q_job.last = 1'b0;
                        word_next  = '0;
                        biw_next   = '0;
                        if (bytes_left_next == '0) begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                default: phase_next = PH_HEADER;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            cnt_left_reg   <= '0;
            accum_reg      <= '0;
            width_reg      <= '0;
            biw_reg        <= '0;
            bytes_left_reg <= '0;
            word_reg       <= '0;
        end else begin
            phase_reg      <= phase_next;
            cnt_left_reg   <= cnt_left_next;
            accum_reg      <= accum_next;
            width_reg      <= width_next;
            biw_reg        <= biw_next;
            bytes_left_reg <= bytes_left_next;
            word_reg       <= word_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bu_back.sv
// bu_back: pops jobs, emits header and error results, unpacks words
// depends on bu_pkg; drives the result register of the block
`default_nettype none

module bu_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 q_empty,
    input  bu_pkg::job_t        q_job,
    output logic                q_pop,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [1:0]          m_kind,
    output logic [30:0]         m_element_value,
    output logic [31:0]         m_element_count,
    output logic [4:0]          m_bit_width,
    output logic [1:0]          m_error_code,
    output logic                m_last
);

    logic        act_reg, act_next;
    logic [62:0] buf_reg, buf_next;
    logic [5:0]  avail_reg, avail_next;
    logic [31:0] left_reg, left_next;
    logic [4:0]  wid_reg, wid_next;

    logic        valid_reg, valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [30:0] value_reg, value_next;
    logic [31:0] count_reg, count_next;
    logic [4:0]  bw_reg, bw_next;
    logic [1:0]  err_reg, err_next;
    logic        last_reg, last_next;

    logic        out_free;
    logic        can_emit;
    logic [5:0]  wid6;
    logic [5:0]  avail_rem;
    logic [62:0] shifted;
    logic [31:0] mask;

    assign out_free  = !valid_reg || m_ready;
    assign wid6      = {1'b0, wid_reg};
    assign can_emit  = act_reg && (left_reg != '0) && (avail_reg >= wid6);
    assign avail_rem = avail_reg - wid6;
    assign shifted   = buf_reg >> avail_rem;
    assign mask      = (32'd1 << wid_reg) - 32'd1;
    assign q_pop     = !act_reg && !q_empty
                       && (q_job.op == bu_pkg::OP_WORD || out_free);

    always_comb begin
        act_next   = act_reg;
        buf_next   = buf_reg;
        avail_next = avail_reg;
        left_next  = left_reg;
        wid_next   = wid_reg;
        valid_next = valid_reg && !m_ready;
        kind_next  = kind_reg;
        value_next = value_reg;
        count_next = count_reg;
        bw_next    = bw_reg;
        err_next   = err_reg;
        last_next  = last_reg;

        if (act_reg) begin
            if (!can_emit) begin
                act_next = 1'b0;
            end else if (out_free) begin
                valid_next = 1'b1;
                kind_next  = bu_pkg::KIND_ELEMENT;
                value_next = shifted[30:0] & mask[30:0];
                count_next = '0;
                bw_next    = '0;
                err_next   = bu_pkg::ERR_NONE;
                last_next  = (left_reg == 32'd1);
                left_next  = left_reg - 32'd1;
                avail_next = avail_rem;
                // word is spent once the last element goes out or the next element no longer fits
                if (left_reg == 32'd1 || avail_rem < wid6) begin
                    act_next = 1'b0;
                end
            end
        end else if (q_pop) begin
            case (q_job.op)
                bu_pkg::OP_WORD: begin
                    // carry bits above avail are never read
                    buf_next   = {buf_reg[30:0], q_job.data};
                    avail_next = avail_reg + 6'd32;
                    act_next   = 1'b1;
                end
                bu_pkg::OP_HEADER: begin
                    valid_next = 1'b1;
                    kind_next  = bu_pkg::KIND_HEADER;
                    value_next = '0;
                    count_next = q_job.data;
                    bw_next    = q_job.width;
                    err_next   = bu_pkg::ERR_NONE;
                    last_next  = q_job.last;
                    left_next  = q_job.data;
                    wid_next   = q_job.width;
                    avail_next = '0;
                end
                bu_pkg::OP_ERROR: begin
                    valid_next = 1'b1;
                    kind_next  = bu_pkg::KIND_ERROR;
                    value_next = '0;
                    count_next = '0;
                    bw_next    = '0;
                    err_next   = q_job.err;
                    last_next  = 1'b1;
                end
                default: act_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg   <= 1'b0;
            avail_reg <= '0;
            left_reg  <= '0;
            wid_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            act_reg   <= act_next;
            avail_reg <= avail_next;
            left_reg  <= left_next;
            wid_reg   <= wid_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg   <= buf_next;
        kind_reg  <= kind_next;
        value_reg <= value_next;
        count_reg <= count_next;
        bw_reg    <= bw_next;
        err_reg   <= err_next;
        last_reg  <= last_next;
    end

    assign m_valid         = valid_reg;
    assign m_kind          = kind_reg;
    assign m_element_value = value_reg;
    assign m_element_count = count_reg;
    assign m_bit_width     = bw_reg;
    assign m_error_code    = err_reg;
    assign m_last          = last_reg;

    a_word_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_job.op == bu_pkg::OP_WORD) |-> (left_reg != '0 && wid_reg != '0))
        else $error("data word arrived with no elements outstanding");

    // leftover bits after the final element are dropped at the next header
    a_carry_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (!act_reg && left_reg != '0) |-> (avail_reg < 6'd31))
        else $error("carry longer than an element between words");

    a_element_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg == bu_pkg::KIND_ELEMENT && $rose(valid_reg))
        |-> ((value_reg & ~mask[30:0]) == '0))
        else $error("element value wider than its width");

endmodule

`default_nettype wire

>>> hw/rtl/bit_unstuffer_top.sv
// bit_unstuffer_top: top level of the bit unstuffer
// depends on bu_pkg, bu_front, bu_fifo, bu_back
`default_nettype none

// Takes one byte per cycle whenever the four-entry job queue has room. A
// header byte and its one, two or four count bytes give one header or error
// result (a header byte with count size code 3 alone gives an error); data
// bytes are packed into 32-bit words, each word queued as one job. The
// unpacking unit in the back loads a word and then releases one element per
// cycle while the output register is free; from about 11-bit elements up the
// byte input side sets the pace. Results sit in an output register, so the
// next item is taken while a result waits.

module bit_unstuffer_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_data_byte,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_kind,
    output logic [30:0] m_element_value,
    output logic [31:0] m_element_count,
    output logic [4:0]  m_bit_width,
    output logic [1:0]  m_error_code,
    output logic        m_last
);

    bu_pkg::job_t push_job;
    bu_pkg::job_t pop_job;
    logic         push;
    logic         pop;
    logic         q_full;
    logic         q_empty;

    bu_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_full      (q_full),
        .q_push      (push),
        .q_job       (push_job)
    );

    bu_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data (push_job),
        .full    (q_full),
        .rd_en   (pop),
        .rd_data (pop_job),
        .empty   (q_empty)
    );

    bu_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_job           (pop_job),
        .q_pop           (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_element_value (m_element_value),
        .m_element_count (m_element_count),
        .m_bit_width     (m_bit_width),
        .m_error_code    (m_error_code),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire
